// ----- hdl/irp_pkg.sv -----
package irp_pkg;

    localparam int POS_W   = 32;          // interval edge width
    localparam int START_W = POS_W + 1;   // widened start, signed
    localparam int LIM_W   = POS_W + 3;   // doubled-length bound, signed
    localparam int GAP_W   = 16;
    localparam int RLIM_W  = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_OUT_W = 8;

    // configuration register indexes
    localparam logic CFG_MIN_GAP   = 1'b0;
    localparam logic CFG_ROW_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_PICK
    } irp_state_t;

    // broadcast from the control to every cell of the row chain
    typedef struct packed {
        logic                      cmp_en;   // latch fit / keep flags
        logic                      pick_en;  // commit placement
        logic                      open_en;  // no fit, open row at count
        logic signed [START_W-1:0] s;        // left_edge - min_gap
        logic signed [LIM_W-1:0]   t;        // 2*right_edge - s + 2
        logic [POS_W-1:0]          right;
    } irp_bcast_t;

endpackage

// ----- hdl/irp_cell.sv -----
module irp_cell #(
    parameter int MAX_ROWS = 256,
    parameter int CELL_IDX = 0
) (
    input  logic                                clk,
    input  irp_pkg::irp_bcast_t                 bcast,
    input  logic [$clog2(MAX_ROWS+1)-1:0]       count,
    input  logic [irp_pkg::POS_W-1:0]           prev_end,
    output logic [irp_pkg::POS_W-1:0]           row_end,
    input  logic                                taken_in,
    output logic                                taken_out,
    output logic                                win
);
    import irp_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);
    localparam logic HAS_PREV = (CELL_IDX != 0);

    logic [POS_W-1:0] end_reg;
    logic             fit_reg;
    logic             keep_reg;
    logic             occupied;
    logic             fit_now;
    logic             keep_now;

    assign occupied = (MY_IDX < count);
    assign fit_now  = occupied && ($signed({1'b0, end_reg}) < $signed(bcast.s));
    // keep the upper row's end when the interval sits inside its reach
    // and is long against the gap to that end
    assign keep_now = HAS_PREV
                      && ({1'b0, bcast.right} < {1'b0, prev_end})
                      && ($signed({3'b000, prev_end}) < $signed(bcast.t));

    assign win       = bcast.pick_en && fit_reg && !taken_in;
    assign taken_out = taken_in || fit_reg;
    assign row_end   = end_reg;

    always_ff @(posedge clk)
    begin
        if (bcast.cmp_en)
        begin
            fit_reg  <= fit_now;
            keep_reg <= keep_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win)
        begin
            end_reg <= keep_reg ? prev_end : bcast.right;
        end
        else if (bcast.open_en && (MY_IDX == count))
        begin
            end_reg <= bcast.right;
        end
    end

endmodule

// ----- hdl/interval_row_packer.sv -----
// Greedy first-fit interval row packer. Intervals arrive sorted by left
// edge, one per input item (s_tdata: left_edge, right_edge; s_tuser:
// start_group, which empties the row table first). Each open row is a cell
// in a chain that holds the row's end position; every cell sees the
// interval at once and its upper neighbor's end. An item goes through a
// compare cycle and then a pick cycle: in the compare cycle each cell
// registers whether its row end lies before left_edge - min_gap and whether
// to copy the upper row's end; in the pick cycle a first-fit carry ripples
// down the chain, the winning cell (or, when nothing fits and a row may be
// opened, the cell at row_count) takes the new end, and the result is loaded
// into the output register. The next item is accepted in that same pick
// cycle. The pick cycle waits while the output register still holds an
// untaken result. A hidden interval reports row 0; overflow marks a hide
// because all MAX_ROWS rows are in use. Row numbers above 255 are reported
// by their low 8 bits. No clearing pass is needed after reset: rows at or
// above row_count are never consulted.
module interval_row_packer #(
    parameter int MAX_ROWS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] left_edge, [63:32] right_edge
    input  logic [0:0]   s_tuser,   // [0] start_group
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [7:0] row_index, [8] visible,
                                    // [9] opened_row, [10] overflow, rest 0
    // configuration
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import irp_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam int CMP_W = (CNT_W > RLIM_W) ? CNT_W : RLIM_W;

    // configuration
    logic [GAP_W-1:0]  min_gap_reg;
    logic [RLIM_W-1:0] row_limit_reg;

    // control
    irp_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // current interval
    logic signed [START_W-1:0] s_reg;
    logic signed [LIM_W-1:0]   t_reg;
    logic [POS_W-1:0]          right_reg;
    logic signed [START_W-1:0] s_new;
    logic signed [LIM_W-1:0]   t_new;
    logic [POS_W-1:0]          left_in;
    logic [POS_W-1:0]          right_in;

    // output register
    logic                  m_valid_reg;
    logic [IDX_OUT_W-1:0]  row_index_reg;
    logic                  visible_reg;
    logic                  opened_reg;
    logic                  overflow_reg;

    // handshake and decision
    logic in_acc;
    logic out_load_ok;
    logic pick_en;
    logic any_fit;
    logic lim_block;
    logic full;
    logic open_row;
    logic hide_ovf;

    // cell chain
    irp_bcast_t         bcast;
    logic [POS_W-1:0]   row_end_w [MAX_ROWS];
    logic [MAX_ROWS:0]  taken;
    logic [MAX_ROWS-1:0] win;
    logic [IDX_W-1:0]   win_idx;
    logic [IDX_W-1:0]   res_idx;
    logic [IDX_W+IDX_OUT_W-1:0] res_idx_wide;

    assign left_in  = s_tdata[31:0];
    assign right_in = s_tdata[63:32];

    assign out_load_ok = !m_valid_reg || m_tready;
    assign pick_en     = (state_reg == ST_PICK) && out_load_ok;
    assign in_acc      = s_tvalid && s_tready;

    // widened start and the bound for the upper-row copy test:
    // 2*(right - s + 1) > prev - s  <=>  prev < 2*right - s + 2
    assign s_new = $signed({1'b0, left_in}) - $signed({17'b0, min_gap_reg});
    assign t_new = $signed({2'b00, right_in, 1'b0}) - $signed({{2{s_new[START_W-1]}}, s_new})
                   + $signed(LIM_W'(2));

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (out_load_ok)
                    state_next = in_acc ? ST_CMP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CMP:  s_tready = 1'b0;
            ST_PICK: s_tready = out_load_ok;
            default: s_tready = 1'b0;
        endcase
    end

    // ---------------- placement decision ----------------
    assign any_fit   = taken[MAX_ROWS];
    assign lim_block = (row_limit_reg != '0)
                       && (CMP_W'(count_reg) > CMP_W'(row_limit_reg));
    assign full      = (count_reg == CNT_W'(MAX_ROWS));
    assign open_row  = !any_fit && !lim_block && !full;
    assign hide_ovf  = !any_fit && !lim_block && full;

    always_comb
    begin
        win_idx = '0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (win[i])
                win_idx = win_idx | IDX_W'(i);
        end
    end

    always_comb
    begin
        priority if (any_fit)
            res_idx = win_idx;
        else if (open_row)
            res_idx = count_reg[IDX_W-1:0];
        else
            res_idx = '0;
    end

    assign res_idx_wide = {{IDX_OUT_W{1'b0}}, res_idx};

    always_comb
    begin
        priority if (in_acc && s_tuser[0])
            count_next = '0;
        else if (pick_en && open_row)
            count_next = count_reg + CNT_W'(1);
        else
            count_next = count_reg;
    end

    // ---------------- cell chain ----------------
    always_comb
    begin
        bcast.cmp_en  = (state_reg == ST_CMP);
        bcast.pick_en = pick_en;
        bcast.open_en = pick_en && open_row;
        bcast.s       = s_reg;
        bcast.t       = t_reg;
        bcast.right   = right_reg;
    end

    assign taken[0] = 1'b0;

    for (genvar g = 0; g < MAX_ROWS; g++)
    begin : g_cell
        logic [POS_W-1:0] prev_end;
        if (g == 0)
        begin : g_first
            assign prev_end = '0;
        end
        else
        begin : g_rest
            assign prev_end = row_end_w[g-1];
        end

        irp_cell #(
            .MAX_ROWS (MAX_ROWS),
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .bcast     (bcast),
            .count     (count_reg),
            .prev_end  (prev_end),
            .row_end   (row_end_w[g]),
            .taken_in  (taken[g]),
            .taken_out (taken[g+1]),
            .win       (win[g])
        );
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            min_gap_reg   <= '0;
            row_limit_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_index[0])
                    CFG_MIN_GAP:   min_gap_reg   <= cfg_data[GAP_W-1:0];
                    CFG_ROW_LIMIT: row_limit_reg <= cfg_data[RLIM_W-1:0];
                    default:       min_gap_reg   <= min_gap_reg;
                endcase
            end
            if (pick_en)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s_reg     <= s_new;
            t_reg     <= t_new;
            right_reg <= right_in;
        end
        if (pick_en)
        begin
            row_index_reg <= res_idx_wide[IDX_OUT_W-1:0];
            visible_reg   <= any_fit || open_row;
            opened_reg    <= open_row;
            overflow_reg  <= hide_ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, overflow_reg, opened_reg, visible_reg, row_index_reg};

    // ---------------- assertions ----------------
    a_one_winner: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(win))
        else $error("more than one row took the interval");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROWS))
        else $error("row count beyond store size");

    a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_PICK))
        else $error("result appeared outside a pick cycle");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[10] && m_tdata[8]) && !(m_tdata[9] && !m_tdata[8]))
        else $error("inconsistent result flags");

endmodule
